[rtl/core/arpc_pkg.sv]
// Shared types and constants for the ARP cache core.
package arpc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);

  localparam logic [15:0] OP_REQUEST      = 16'd1;
  localparam logic [31:0] TIMEOUT_RST     = 32'd6000;

  // configuration register indexes
  localparam logic CFG_LOCAL_IP = 1'b0;
  localparam logic CFG_TIMEOUT  = 1'b1;

  localparam logic REQ_LEARN   = 1'b0;
  localparam logic REQ_RESOLVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] ip_addr;
    logic [47:0] mac_addr;
    logic [15:0] arp_opcode;
    logic [31:0] tgt_ip;
    logic [31:0] time_now;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] mac_out;
    logic        send_request;
    logic        send_reply;
    logic        learned;
    logic        table_full;
  } result_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           entry;
  } tbl_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } tbl_rd_t;

  typedef struct packed {
    logic [31:0] local_ip;
    logic [31:0] timeout_ticks;
  } cfg_t;

endpackage

[rtl/core/arpc_if.sv]
// Valid/ready channel interfaces for request and result beats.
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] ip_addr;
  logic [47:0] mac_addr;
  logic [15:0] arp_opcode;
  logic [31:0] tgt_ip;
  logic [31:0] time_now;

  modport source (
    output valid, req_type, ip_addr, mac_addr, arp_opcode, tgt_ip, time_now,
    input  ready
  );
  modport sink (
    input  valid, req_type, ip_addr, mac_addr, arp_opcode, tgt_ip, time_now,
    output ready
  );
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [47:0] mac_out;
  logic        send_request;
  logic        send_reply;
  logic        learned;
  logic        table_full;

  modport source (
    output valid, hit, mac_out, send_request, send_reply, learned, table_full,
    input  ready
  );
  modport sink (
    input  valid, hit, mac_out, send_request, send_reply, learned, table_full,
    output ready
  );
endinterface

[rtl/core/arpc_table.sv]
// Entry store: synchronous RAM for ip/mac/stamp plus flop valid bits.
module arpc_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [arpc_pkg::IDX_W-1:0] rd_addr,
  input  arpc_pkg::tbl_wr_t        wr,
  output arpc_pkg::tbl_rd_t        rd
);
  import arpc_pkg::*;

  entry_t             mem_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  entry_t             rd_entry_r;
  logic               rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.entry;
    end
    rd_entry_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd.valid = rd_valid_r;
  assign rd.entry = rd_entry_r;

endmodule

[rtl/core/arpc_scan.sv]
// Per-item sequencer: scans the table one entry a cycle and builds the result.
module arpc_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  arpc_pkg::cfg_t             cfg,
  arpc_in_if.sink                    in_bus,
  arpc_out_if.source                 out_bus,
  output logic [arpc_pkg::IDX_W-1:0] rd_addr,
  output arpc_pkg::tbl_wr_t          tbl_wr,
  input  arpc_pkg::tbl_rd_t          tbl_rd
);
  import arpc_pkg::*;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  item_t            item_r;
  result_t          res_r, res_nxt;
  result_t          out_r;
  logic             out_valid_r, out_valid_nxt;

  logic        in_fire;
  logic        out_free;
  logic        ip_eq;
  logic [31:0] age;
  logic        found;
  logic        last;
  logic        load_item;
  logic        load_res;
  logic        load_out;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;

  // entry data lines up with cmp_idx_r: its address went out last cycle
  assign ip_eq = (tbl_rd.entry.ip == item_r.ip_addr);
  assign age   = item_r.time_now - tbl_rd.entry.stamp;
  assign last  = (cmp_idx_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    if (item_r.req_type == REQ_LEARN) begin
      found = !tbl_rd.valid || ip_eq;
    end else begin
      found = tbl_rd.valid && ip_eq && (age < cfg.timeout_ticks);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_bus.valid) state_nxt = ST_SCAN;
      ST_SCAN: if (found || last) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_bus.ready = 1'b0;
    load_item    = 1'b0;
    load_res     = 1'b0;
    load_out     = 1'b0;
    rd_addr      = '0;
    cmp_idx_nxt  = cmp_idx_r;
    tbl_wr.en    = 1'b0;
    tbl_wr.addr  = cmp_idx_r;
    tbl_wr.entry = '{ip: item_r.ip_addr, mac: item_r.mac_addr, stamp: item_r.time_now};
    unique case (state_r)
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        load_item    = in_bus.valid;
        cmp_idx_nxt  = '0;
      end
      ST_SCAN: begin
        rd_addr     = cmp_idx_r + IDX_W'(1);
        cmp_idx_nxt = cmp_idx_r + IDX_W'(1);
        load_res    = found || last;
        tbl_wr.en   = found && (item_r.req_type == REQ_LEARN);
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_bus.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (item_r.req_type == REQ_LEARN) begin
      res_nxt.learned    = found;
      res_nxt.table_full = !found;
      res_nxt.send_reply = (item_r.arp_opcode == OP_REQUEST) &&
                           (item_r.tgt_ip == cfg.local_ip);
    end else begin
      res_nxt.hit          = found;
      res_nxt.mac_out      = found ? tbl_rd.entry.mac : 48'd0;
      res_nxt.send_request = !found;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmp_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_idx_r   <= cmp_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      item_r <= '{req_type:   in_bus.req_type,
                  ip_addr:    in_bus.ip_addr,
                  mac_addr:   in_bus.mac_addr,
                  arp_opcode: in_bus.arp_opcode,
                  tgt_ip:     in_bus.tgt_ip,
                  time_now:   in_bus.time_now};
    end
    if (load_res) begin
      res_r <= res_nxt;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.hit          = out_r.hit;
  assign out_bus.mac_out      = out_r.mac_out;
  assign out_bus.send_request = out_r.send_request;
  assign out_bus.send_reply   = out_r.send_reply;
  assign out_bus.learned      = out_r.learned;
  assign out_bus.table_full   = out_r.table_full;

`ifndef SYNTHESIS
  a_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_wr.en |-> (state_r == ST_SCAN) && (item_r.req_type == REQ_LEARN))
    else $error("table write outside a learn scan");

  a_scan_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SCAN) && (cmp_idx_r == '0))
    else $error("scan did not start at entry zero");

  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot({out_r.hit, out_r.send_request, out_r.learned,
                             out_r.table_full}))
    else $error("result carries no single outcome");

  a_mac_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |-> (out_r.mac_out == 48'd0))
    else $error("mac_out nonzero without a hit");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("finished result not moved to the output register");
`endif

endmodule

[rtl/core/arp_cache_learn_resolve_core.sv]
// ARP cache core: config registers, entry table and scan sequencer.
//
//   channel  | dir | handshake         | beat contents
//   ---------+-----+-------------------+----------------------------------------
//   in_bus   | in  | valid/ready       | req_type, ip_addr, mac_addr, opcode, ...
//   out_bus  | out | valid/ready       | hit, mac_out, send_request/reply, ...
//   cfg_*    | in  | cfg_we, no ready  | cfg_idx selects local_ip or timeout
//
// One item at a time: accept, then one table entry per cycle (up to ENTRIES,
// stopping at the first match), then a move into the output register once it
// is free; the scan is bound by the single table read port.
// Reset (rst_n low, synchronous) clears all valid bits.
// A stalled result is held while the next beat is taken and scanned.
module arp_cache_learn_resolve_core (
  input  logic        clk,
  input  logic        rst_n,
  arpc_in_if.sink     in_bus,
  arpc_out_if.source  out_bus,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [31:0] cfg_data
);
  import arpc_pkg::*;

  cfg_t             cfg_r;
  logic [IDX_W-1:0] rd_addr;
  tbl_wr_t          tbl_wr;
  tbl_rd_t          tbl_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_ip      <= '0;
      cfg_r.timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LOCAL_IP: cfg_r.local_ip      <= cfg_data;
        CFG_TIMEOUT:  cfg_r.timeout_ticks <= cfg_data;
        default:      cfg_r.local_ip      <= cfg_r.local_ip;
      endcase
    end
  end

  arpc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .wr      (tbl_wr),
    .rd      (tbl_rd)
  );

  arpc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .rd_addr (rd_addr),
    .tbl_wr  (tbl_wr),
    .tbl_rd  (tbl_rd)
  );

endmodule
